// File: hw/rtl/abbb_pkg.sv
// shared constants, types and ring-pointer helpers of the alternating-bit byte bridge
// depends on nothing; imported by every module of the block except abbb_ram
package abbb_pkg;

    localparam int RING_DEPTH   = 2048;
    localparam int CHUNK_MAX    = 32;
    localparam int CREDIT_SHIFT = 4;
    localparam int CREDIT_MAX   = 255;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int LEN_W        = $clog2(CHUNK_MAX + 1);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [PTR_W:0]   t_sum;
    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [1:0] {
        CMD_HDR   = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_HDR   = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic emit_host;
        logic emit_hdr;
        logic emit_byte;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic oversize;
        logic len_zero;
        logic pend_one;
        logic flight_zero;
        logic ofs_last;
        logic out_free;
    } t_dp_stat;

    function automatic t_ptr ptr_inc(t_ptr p);
        return (p == t_ptr'(RING_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_add(t_ptr p, t_len n);
        t_sum s;
        s = t_sum'(p) + t_sum'(n);
        if (s >= t_sum'(RING_DEPTH)) begin
            s = s - t_sum'(RING_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic t_ptr ring_used(t_ptr head, t_ptr tail);
        t_sum s;
        s = t_sum'(head) + t_sum'(RING_DEPTH) - t_sum'(tail);
        return (head >= tail) ? head - tail : s[PTR_W-1:0];
    endfunction

    function automatic logic [7:0] credit_of(t_ptr free_bytes);
        logic [31:0] c;
        c = 32'(free_bytes) >> CREDIT_SHIFT;
        return (c > 32'(CREDIT_MAX)) ? 8'(CREDIT_MAX) : c[7:0];
    endfunction

endpackage

// File: hw/rtl/abbb_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read data holds while no read is issued
module abbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/abbb_ctrl.sv
// sequencing state machine: accept, execute, host answer, response run
// depends on abbb_pkg; drives the datapath through t_dp_cmd
module abbb_ctrl
    import abbb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_HOST  = 5'b00100,
        S_RHDR  = 5'b01000,
        S_RBYTE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_stat.cmd)
                    CMD_HDR: begin
                        n_state = (!i_stat.oversize && i_stat.len_zero) ? S_RHDR : S_IDLE;
                    end
                    CMD_DATA: begin
                        n_state = i_stat.pend_one ? S_RHDR : S_IDLE;
                    end
                    default: begin
                        n_state = S_HOST;
                    end
                endcase
            end
            S_HOST: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_host = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RHDR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    n_state        = i_stat.flight_zero ? S_IDLE : S_RBYTE;
                end
            end
            S_RBYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    n_state         = i_stat.ofs_last ? S_IDLE : S_RBYTE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hw/rtl/abbb_dp.sv
// datapath: input latch, ring pointers, protocol flags, both rings, output register
// depends on abbb_pkg and abbb_ram; steered by abbb_ctrl
module abbb_dp
    import abbb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    input  logic [1:0] i_cmd_code,
    input  logic       i_seq_in_flag,
    input  logic       i_ack_in_flag,
    input  logic [7:0] i_link_status_in,
    input  logic [7:0] i_in_len,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic       o_seq_out_flag,
    output logic       o_ack_out_flag,
    output logic [7:0] o_credit,
    output t_len       o_offer_len,
    output logic [7:0] o_byte_out,
    output logic       o_ok,
    output logic       o_last_item,
    output t_ptr       o_rx_count,
    output logic [7:0] o_link_status_out
);

    // latched input word
    t_cmd       r_cmd;
    logic       r_seq;
    logic       r_ack;
    logic [7:0] r_lsin;
    logic [7:0] r_len;
    logic [7:0] r_byte;

    // protocol state
    t_ptr       r_rx_head, n_rx_head;
    t_ptr       r_rx_tail, n_rx_tail;
    t_ptr       r_tx_head, n_tx_head;
    t_ptr       r_tx_tail, n_tx_tail;
    logic       r_acc_seq, n_acc_seq;
    logic       r_offer_seq, n_offer_seq;
    t_len       r_in_flight, n_in_flight;
    logic [7:0] r_link_status, n_link_status;
    t_len       r_pending, n_pending;
    logic       r_pend_acc, n_pend_acc;
    logic       r_hok, n_hok;
    t_len       r_ofs, n_ofs;

    // output register
    logic       r_out_valid;
    t_kind      r_kind;
    logic       r_oseq;
    logic       r_oack;
    logic [7:0] r_credit;
    t_len       r_olen;
    logic [7:0] r_obyte;
    logic       r_ok;
    logic       r_last;
    t_ptr       r_rx_count;
    logic [7:0] r_olink;

    // ring ports
    logic       rx_we, rx_re, tx_we, tx_re;
    t_ptr       tx_raddr;
    logic [7:0] rx_rdata, tx_rdata;

    t_ptr       rx_used, tx_used, rx_free, tx_tail_ret, tx_used_ret;
    t_len       len_s;
    logic       retire, out_free, load;

    assign rx_used = ring_used(r_rx_head, r_rx_tail);
    assign tx_used = ring_used(r_tx_head, r_tx_tail);
    assign rx_free = t_ptr'(RING_DEPTH - 1) - rx_used;
    assign len_s   = r_len[LEN_W-1:0];
    assign retire  = (r_in_flight != '0) && (r_ack == r_offer_seq);
    assign tx_tail_ret = retire ? ptr_add(r_tx_tail, r_in_flight) : r_tx_tail;
    assign tx_used_ret = ring_used(r_tx_head, tx_tail_ret);

    always_comb begin
        n_rx_head     = r_rx_head;
        n_rx_tail     = r_rx_tail;
        n_tx_head     = r_tx_head;
        n_tx_tail     = r_tx_tail;
        n_acc_seq     = r_acc_seq;
        n_offer_seq   = r_offer_seq;
        n_in_flight   = r_in_flight;
        n_link_status = r_link_status;
        n_pending     = r_pending;
        n_pend_acc    = r_pend_acc;
        n_hok         = r_hok;
        n_ofs         = r_ofs;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        tx_we         = 1'b0;
        tx_re         = 1'b0;
        tx_raddr      = r_tx_tail;

        if (i_cmd.exec) begin
            case (r_cmd)
                CMD_HDR: begin
                    n_link_status = r_lsin;
                    n_pending     = '0;
                    n_pend_acc    = 1'b0;
                    if (r_len <= 8'(CHUNK_MAX)) begin
                        if (len_s != '0) begin
                            if (r_seq != r_acc_seq && t_ptr'(len_s) <= rx_free) begin
                                n_pend_acc = 1'b1;
                                n_acc_seq  = r_seq;
                            end
                        end else begin
                            n_acc_seq = r_seq;
                        end
                        n_tx_tail = tx_tail_ret;
                        if (retire) begin
                            n_offer_seq = ~r_offer_seq;
                        end
                        // pick the next chunk once nothing is in flight
                        if (retire || r_in_flight == '0) begin
                            n_in_flight = (tx_used_ret > t_ptr'(CHUNK_MAX)) ?
                                          t_len'(CHUNK_MAX) : t_len'(tx_used_ret);
                        end
                        n_pending = len_s;
                    end
                end
                CMD_DATA: begin
                    if (r_pending != '0) begin
                        if (r_pend_acc) begin
                            rx_we     = 1'b1;
                            n_rx_head = ptr_inc(r_rx_head);
                        end
                        n_pending = r_pending - t_len'(1);
                        if (r_pending == t_len'(1)) begin
                            n_pend_acc = 1'b0;
                        end
                    end
                end
                CMD_READ: begin
                    n_hok = (rx_used != '0);
                    if (rx_used != '0) begin
                        rx_re     = 1'b1;
                        n_rx_tail = ptr_inc(r_rx_tail);
                    end
                end
                default: begin
                    n_hok = (tx_used < t_ptr'(RING_DEPTH - 1));
                    if (tx_used < t_ptr'(RING_DEPTH - 1)) begin
                        tx_we     = 1'b1;
                        n_tx_head = ptr_inc(r_tx_head);
                    end
                end
            endcase
        end

        // offered bytes are fetched one ahead of the output register
        if (i_cmd.emit_hdr && r_in_flight != '0) begin
            tx_re = 1'b1;
            n_ofs = t_len'(1);
        end
        if (i_cmd.emit_byte && r_ofs != r_in_flight) begin
            tx_re    = 1'b1;
            tx_raddr = ptr_add(r_tx_tail, r_ofs);
            n_ofs    = r_ofs + t_len'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= t_cmd'(i_cmd_code);
            r_seq  <= i_seq_in_flag;
            r_ack  <= i_ack_in_flag;
            r_lsin <= i_link_status_in;
            r_len  <= i_in_len;
            r_byte <= i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head     <= '0;
            r_rx_tail     <= '0;
            r_tx_head     <= '0;
            r_tx_tail     <= '0;
            r_acc_seq     <= 1'b1;
            r_offer_seq   <= 1'b0;
            r_in_flight   <= '0;
            r_link_status <= '0;
            r_pending     <= '0;
            r_pend_acc    <= 1'b0;
            r_hok         <= 1'b0;
            r_ofs         <= '0;
        end else begin
            r_rx_head     <= n_rx_head;
            r_rx_tail     <= n_rx_tail;
            r_tx_head     <= n_tx_head;
            r_tx_tail     <= n_tx_tail;
            r_acc_seq     <= n_acc_seq;
            r_offer_seq   <= n_offer_seq;
            r_in_flight   <= n_in_flight;
            r_link_status <= n_link_status;
            r_pending     <= n_pending;
            r_pend_acc    <= n_pend_acc;
            r_hok         <= n_hok;
            r_ofs         <= n_ofs;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign load     = i_cmd.emit_host || i_cmd.emit_hdr || i_cmd.emit_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_oseq     <= r_offer_seq;
            r_oack     <= r_acc_seq;
            r_credit   <= credit_of(rx_free);
            r_rx_count <= rx_used;
            r_olink    <= r_link_status;
            if (i_cmd.emit_host) begin
                r_kind  <= (r_cmd == CMD_READ) ? KIND_READ : KIND_WRITE;
                r_olen  <= '0;
                r_obyte <= (r_cmd == CMD_READ && r_hok) ? rx_rdata : 8'd0;
                r_ok    <= r_hok;
                r_last  <= 1'b0;
            end else if (i_cmd.emit_hdr) begin
                r_kind  <= KIND_HDR;
                r_olen  <= r_in_flight;
                r_obyte <= 8'd0;
                r_ok    <= 1'b0;
                r_last  <= (r_in_flight == '0);
            end else begin
                r_kind  <= KIND_BYTE;
                r_olen  <= r_in_flight;
                r_obyte <= tx_rdata;
                r_ok    <= 1'b0;
                r_last  <= (r_ofs == r_in_flight);
            end
        end
    end

    abbb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (r_byte),
        .i_re    (rx_re),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    abbb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (r_byte),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    assign o_stat.cmd         = r_cmd;
    assign o_stat.oversize    = (r_len > 8'(CHUNK_MAX));
    assign o_stat.len_zero    = (r_len == 8'd0);
    assign o_stat.pend_one    = (r_pending == t_len'(1));
    assign o_stat.flight_zero = (r_in_flight == '0);
    assign o_stat.ofs_last    = (r_ofs == r_in_flight);
    assign o_stat.out_free    = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_seq_out_flag    = r_oseq;
    assign o_ack_out_flag    = r_oack;
    assign o_credit          = r_credit;
    assign o_offer_len       = r_olen;
    assign o_byte_out        = r_obyte;
    assign o_ok              = r_ok;
    assign o_last_item       = r_last;
    assign o_rx_count        = r_rx_count;
    assign o_link_status_out = r_olink;

endmodule

// File: hw/rtl/alternating_bit_byte_bridge_top.sv
// Alternating-bit byte bridge between a link partner and a local host, built from
// two 2048-byte rings. One word is taken at a time: a poll header or poll data byte
// passes through accept and execute, a host read or write through accept, ring access
// and answer into the output register. A header or final data byte that completes a
// poll adds a response run of 1 + offer_len words, one per cycle while the output
// is taken, limited by the single read port of the transmit ring. A word's results
// sit in an output register until taken; the next word is accepted once the run
// has been fully loaded. Ring contents are not cleared at reset and need no sweep.
// depends on abbb_pkg, abbb_ctrl and abbb_dp
module alternating_bit_byte_bridge_top
    import abbb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic       i_seq_in_flag,
    input  logic       i_ack_in_flag,
    input  logic [7:0] i_link_status_in,
    input  logic [7:0] i_in_len,
    input  logic [7:0] i_byte_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic       o_seq_out_flag,
    output logic       o_ack_out_flag,
    output logic [7:0] o_credit,
    output t_len       o_offer_len,
    output logic [7:0] o_byte_out,
    output logic       o_ok,
    output logic       o_last_item,
    output t_ptr       o_rx_count,
    output logic [7:0] o_link_status_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    abbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    abbb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_cmd_code        (i_cmd),
        .i_seq_in_flag     (i_seq_in_flag),
        .i_ack_in_flag     (i_ack_in_flag),
        .i_link_status_in  (i_link_status_in),
        .i_in_len          (i_in_len),
        .i_byte_in         (i_byte_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_seq_out_flag    (o_seq_out_flag),
        .o_ack_out_flag    (o_ack_out_flag),
        .o_credit          (o_credit),
        .o_offer_len       (o_offer_len),
        .o_byte_out        (o_byte_out),
        .o_ok              (o_ok),
        .o_last_item       (o_last_item),
        .o_rx_count        (o_rx_count),
        .o_link_status_out (o_link_status_out)
    );

endmodule

// File: hw/rtl/abbb_chk.sv
// port-level checks of the alternating-bit byte bridge, bound to the top level
// depends on abbb_pkg
module abbb_chk
    import abbb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_cmd,
    input logic       i_seq_in_flag,
    input logic       i_ack_in_flag,
    input logic [7:0] i_link_status_in,
    input logic [7:0] i_in_len,
    input logic [7:0] i_byte_in,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_kind,
    input logic       o_seq_out_flag,
    input logic       o_ack_out_flag,
    input logic [7:0] o_credit,
    input t_len       o_offer_len,
    input logic [7:0] o_byte_out,
    input logic       o_ok,
    input logic       o_last_item,
    input t_ptr       o_rx_count,
    input logic [7:0] o_link_status_out
);

    // a word is never followed by another in the very next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // host answers carry no run framing
    a_host_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_READ || o_kind == KIND_WRITE))
        |-> (o_offer_len == '0 && !o_last_item))
        else $error("host answer with run framing");

    // response header and offered bytes agree on the chunk size
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_HDR || o_kind == KIND_BYTE))
        |-> (o_offer_len <= t_len'(CHUNK_MAX)
             && (o_kind == KIND_HDR || o_offer_len != '0)
             && (o_kind != KIND_HDR || o_last_item == (o_offer_len == '0))))
        else $error("response run framing wrong");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
        |=> (o_out_valid && $stable(o_byte_out) && $stable(o_kind)))
        else $error("stalled result changed");

endmodule

bind alternating_bit_byte_bridge_top abbb_chk u_abbb_chk (.*);

// File: dv/alternating_bit_byte_bridge_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for alternating_bit_byte_bridge_top: a queue-fed word driver,
// a checking monitor and a predictor of both rings, the flag bits and the poll runs
// depends on abbb_pkg and the bridge rtl
module alternating_bit_byte_bridge_top_tb;
    import abbb_pkg::*;

    localparam int RANDOM_WORDS  = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PRINT_MAX     = 200;

    typedef struct packed {
        t_cmd       cmd;
        logic       seq;
        logic       ack;
        logic [7:0] status;
        logic [7:0] len;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        t_kind      kind;
        logic       seq;
        logic       ack;
        logic [7:0] credit;
        t_len       olen;
        logic [7:0] data;
        logic       ok;
        logic       last;
        t_ptr       rx_count;
        logic [7:0] status;
    } t_out_word;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_ready = 1'b0;
    t_in_word   drv_word    = '0;

    logic       o_in_ready;
    logic [1:0] i_cmd;
    logic       i_seq_in_flag;
    logic       i_ack_in_flag;
    logic [7:0] i_link_status_in;
    logic [7:0] i_in_len;
    logic [7:0] i_byte_in;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic       o_seq_out_flag;
    logic       o_ack_out_flag;
    logic [7:0] o_credit;
    t_len       o_offer_len;
    logic [7:0] o_byte_out;
    logic       o_ok;
    logic       o_last_item;
    t_ptr       o_rx_count;
    logic [7:0] o_link_status_out;

    assign i_cmd            = drv_word.cmd;
    assign i_seq_in_flag    = drv_word.seq;
    assign i_ack_in_flag    = drv_word.ack;
    assign i_link_status_in = drv_word.status;
    assign i_in_len         = drv_word.len;
    assign i_byte_in        = drv_word.data;

    alternating_bit_byte_bridge_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_seq_in_flag     (i_seq_in_flag),
        .i_ack_in_flag     (i_ack_in_flag),
        .i_link_status_in  (i_link_status_in),
        .i_in_len          (i_in_len),
        .i_byte_in         (i_byte_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_seq_out_flag    (o_seq_out_flag),
        .o_ack_out_flag    (o_ack_out_flag),
        .o_credit          (o_credit),
        .o_offer_len       (o_offer_len),
        .o_byte_out        (o_byte_out),
        .o_ok              (o_ok),
        .o_last_item       (o_last_item),
        .o_rx_count        (o_rx_count),
        .o_link_status_out (o_link_status_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0] rx_mem [RING_DEPTH];
    logic [7:0] tx_mem [RING_DEPTH];
    int         rx_wr     = 0;
    int         rx_rd     = 0;
    int         tx_wr     = 0;
    int         tx_rd     = 0;
    int         flight    = 0;
    int         pend_cnt  = 0;
    logic       pend_take = 1'b0;
    logic       acc_seq   = 1'b1;
    logic       off_seq   = 1'b0;
    logic [7:0] link_stat = 8'h00;

    t_in_word   pending_words [$];
    t_out_word  expected_words [$];

    logic calm        = 1'b0;
    int   send_gap    = 0;
    int   take_gap    = 0;
    int   cycle_count = 0;
    int   n_sent      = 0;
    int   n_checked   = 0;
    int   n_errors    = 0;
    int   n_polls_taken   = 0;
    int   n_polls_dropped = 0;
    int   n_oversize      = 0;
    int   n_empty_reads   = 0;
    int   n_full_writes   = 0;

    function automatic int fill_of(int head, int tail);
        return (head + RING_DEPTH - tail) % RING_DEPTH;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= PRINT_MAX) begin
            $display("mismatch in %s: got %0d, expected %0d (result word %0d)",
                     what, got, want, n_checked);
        end
    endtask

    task automatic expect_word(input t_kind kind, input int olen, input logic [7:0] data,
                               input logic ok, input logic last);
        t_out_word r;
        int        used;
        int        crd;
        used = fill_of(rx_wr, rx_rd);
        crd  = (RING_DEPTH - 1 - used) >> CREDIT_SHIFT;
        if (crd > CREDIT_MAX) crd = CREDIT_MAX;
        r.kind     = kind;
        r.seq      = off_seq;
        r.ack      = acc_seq;
        r.credit   = crd[7:0];
        r.olen     = olen[LEN_W-1:0];
        r.data     = data;
        r.ok       = ok;
        r.last     = last;
        r.rx_count = used[PTR_W-1:0];
        r.status   = link_stat;
        expected_words.push_back(r);
    endtask

    task automatic expect_response();
        expect_word(KIND_HDR, flight, 8'h00, 1'b0, flight == 0);
        for (int i = 0; i < flight; i++) begin
            expect_word(KIND_BYTE, flight, tx_mem[(tx_rd + i) % RING_DEPTH], 1'b0,
                        i + 1 == flight);
        end
    endtask

    task automatic bridge_step(input t_in_word w);
        int         freeb;
        int         tx_used;
        logic [7:0] popped;
        case (w.cmd)
            CMD_HDR: begin
                link_stat = w.status;
                pend_cnt  = 0;
                pend_take = 1'b0;
                if (w.len > CHUNK_MAX) begin
                    n_oversize++;
                end else begin
                    if (w.len == 0) begin
                        acc_seq = w.seq;
                    end else begin
                        freeb = RING_DEPTH - 1 - fill_of(rx_wr, rx_rd);
                        if (w.seq != acc_seq && w.len <= freeb) begin
                            pend_take = 1'b1;
                            acc_seq   = w.seq;
                            n_polls_taken++;
                        end else begin
                            n_polls_dropped++;
                        end
                    end
                    // a matching ack retires the bytes on offer and flips our bit
                    if (flight > 0 && w.ack == off_seq) begin
                        tx_rd   = (tx_rd + flight) % RING_DEPTH;
                        flight  = 0;
                        off_seq = ~off_seq;
                    end
                    if (flight == 0) begin
                        tx_used = fill_of(tx_wr, tx_rd);
                        flight  = (tx_used > CHUNK_MAX) ? CHUNK_MAX : tx_used;
                    end
                    pend_cnt = int'(w.len);
                    if (w.len == 0) expect_response();
                end
            end
            CMD_DATA: begin
                if (pend_cnt > 0) begin
                    if (pend_take) begin
                        rx_mem[rx_wr] = w.data;
                        rx_wr = (rx_wr + 1) % RING_DEPTH;
                    end
                    pend_cnt--;
                    if (pend_cnt == 0) begin
                        pend_take = 1'b0;
                        expect_response();
                    end
                end
            end
            CMD_READ: begin
                if (fill_of(rx_wr, rx_rd) > 0) begin
                    popped = rx_mem[rx_rd];
                    rx_rd  = (rx_rd + 1) % RING_DEPTH;
                    expect_word(KIND_READ, 0, popped, 1'b1, 1'b0);
                end else begin
                    n_empty_reads++;
                    expect_word(KIND_READ, 0, 8'h00, 1'b0, 1'b0);
                end
            end
            default: begin
                if (fill_of(tx_wr, tx_rd) < RING_DEPTH - 1) begin
                    tx_mem[tx_wr] = w.data;
                    tx_wr = (tx_wr + 1) % RING_DEPTH;
                    expect_word(KIND_WRITE, 0, 8'h00, 1'b1, 1'b0);
                end else begin
                    n_full_writes++;
                    expect_word(KIND_WRITE, 0, 8'h00, 1'b0, 1'b0);
                end
            end
        endcase
    endtask

    task automatic check_word();
        t_out_word want;
        if (expected_words.size() == 0) begin
            note_mismatch("unexpected result word", 1, 0);
        end else begin
            want = expected_words.pop_front();
            n_checked++;
            if (o_kind !== want.kind) begin
                note_mismatch("kind", int'(o_kind), int'(want.kind));
            end
            if (o_seq_out_flag !== want.seq) begin
                note_mismatch("seq_out_flag", int'(o_seq_out_flag), int'(want.seq));
            end
            if (o_ack_out_flag !== want.ack) begin
                note_mismatch("ack_out_flag", int'(o_ack_out_flag), int'(want.ack));
            end
            if (o_credit !== want.credit) begin
                note_mismatch("credit", int'(o_credit), int'(want.credit));
            end
            if (o_offer_len !== want.olen) begin
                note_mismatch("offer_len", int'(o_offer_len), int'(want.olen));
            end
            if (o_byte_out !== want.data) begin
                note_mismatch("byte_out", int'(o_byte_out), int'(want.data));
            end
            if (o_ok !== want.ok) begin
                note_mismatch("ok", int'(o_ok), int'(want.ok));
            end
            if (o_last_item !== want.last) begin
                note_mismatch("last_item", int'(o_last_item), int'(want.last));
            end
            if (o_rx_count !== want.rx_count) begin
                note_mismatch("rx_count", int'(o_rx_count), int'(want.rx_count));
            end
            if (o_link_status_out !== want.status) begin
                note_mismatch("link_status_out", int'(o_link_status_out), int'(want.status));
            end
        end
    endtask

    // word driver: predicts each word as it is taken, then offers the next or idles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                bridge_step(drv_word);
                n_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    // this cycle is the first of an idle gap
                    send_gap = $urandom_range(0, 12);
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    drv_word   <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_word();
            if (take_gap > 0) begin
                take_gap--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                take_gap = $urandom_range(0, 12);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, expected_words.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_word(input t_cmd c, input logic s, input logic a, input int status,
                              input int len, input int data);
        t_in_word w;
        w.cmd    = c;
        w.seq    = s;
        w.ack    = a;
        w.status = status[7:0];
        w.len    = len[7:0];
        w.data   = data[7:0];
        pending_words.push_back(w);
    endtask

    // host words and stray data: the unused fields carry noise
    task automatic queue_host(input t_cmd c, input int data);
        queue_word(c, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 255), $urandom_range(0, 255), data);
    endtask

    // poll header followed by n_data of its bytes, fewer than len for a broken run
    task automatic queue_poll(input logic s, input logic a, input int status, input int len,
                              input int n_data);
        queue_word(CMD_HDR, s, a, status, len, $urandom_range(0, 255));
        repeat (n_data) queue_host(CMD_DATA, $urandom_range(0, 255));
    endtask

    task automatic wait_quiet();
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic acc_gen;
        logic seq;
        int   n_random;
        int   pick;
        int   len;
        int   cut;

        // directed opening
        queue_host(CMD_READ, 0);                        // read of an empty ring
        queue_host(CMD_DATA, 8'h3C);                    // stray data byte
        queue_host(CMD_WRITE, 8'h00);
        queue_host(CMD_WRITE, 8'hFF);
        queue_host(CMD_WRITE, 8'hA5);
        queue_poll(1'b0, 1'b0, 8'h00, 0, 0);            // empty poll, three bytes offered
        queue_poll(1'b1, 1'b1, 8'hFF, 2, 2);            // data taken, offer repeated
        queue_poll(1'b1, 1'b0, 8'h5A, 1, 1);            // repeat dropped, ack retires
        queue_poll(1'b0, 1'b1, 8'h81, CHUNK_MAX + 1, 0);
        queue_poll(1'b1, 1'b0, 8'h7E, 255, 0);
        queue_poll(1'b0, 1'b0, 8'hC3, 3, 1);            // run cut short by the next header
        queue_poll(1'b1, 1'b1, 8'h18, 0, 0);
        repeat (4) queue_host(CMD_READ, 0);
        acc_gen = 1'b1;

        // random mix, mostly well-formed polls with the partner's bit alternating
        n_random = 0;
        while (n_random < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                case ($urandom_range(0, 9))
                    0:       len = CHUNK_MAX;
                    1, 2:    len = 0;
                    3:       len = $urandom_range(1, CHUNK_MAX);
                    default: len = $urandom_range(1, 8);
                endcase
                if (len == 0) begin
                    seq = ($urandom_range(0, 3) == 0) ? ~acc_gen : acc_gen;
                end else begin
                    seq = ($urandom_range(0, 9) == 0) ? acc_gen : ~acc_gen;
                end
                acc_gen = seq;
                queue_poll(seq, 1'($urandom_range(0, 1)), $urandom_range(0, 255), len, len);
                n_random += 1 + len;
            end else if (pick < 62) begin
                queue_host(CMD_WRITE, $urandom_range(0, 255));
                n_random++;
            end else if (pick < 84) begin
                queue_host(CMD_READ, 0);
                n_random++;
            end else if (pick < 90) begin
                queue_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 255), $urandom_range(CHUNK_MAX + 1, 255), 0);
                n_random++;
            end else if (pick < 95) begin
                len     = $urandom_range(2, 8);
                cut     = $urandom_range(0, len - 1);
                acc_gen = ~acc_gen;
                queue_poll(acc_gen, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                           len, cut);
                n_random += 1 + cut;
            end else begin
                queue_host(CMD_DATA, $urandom_range(0, 255));
                n_random++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_quiet();

        // closing stretch without idling: writes, two taken polls with their runs, reads
        calm = 1'b1;
        repeat (12) queue_host(CMD_WRITE, $urandom_range(0, 255));
        queue_poll(acc_gen, 1'($urandom_range(0, 1)), $urandom_range(0, 255), 0, 0);
        acc_gen = ~acc_gen;
        queue_poll(acc_gen, 1'($urandom_range(0, 1)), $urandom_range(0, 255), 8, 8);
        queue_poll(acc_gen, 1'($urandom_range(0, 1)), $urandom_range(0, 255), 0, 0);
        acc_gen = ~acc_gen;
        queue_poll(acc_gen, 1'($urandom_range(0, 1)), $urandom_range(0, 255), 4, 4);
        repeat (16) queue_host(CMD_READ, 0);
        wait_quiet();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            note_mismatch("results never delivered", expected_words.size(), 0);
        end
        $display("run: %0d words in, %0d result words checked, %0d cycles",
                 n_sent, n_checked, cycle_count);
        $display("polls taken %0d, dropped %0d, oversized %0d; empty reads %0d, full writes %0d",
                 n_polls_taken, n_polls_dropped, n_oversize, n_empty_reads, n_full_writes);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/abbb_pkg.sv
hw/rtl/abbb_ram.sv
hw/rtl/abbb_ctrl.sv
hw/rtl/abbb_dp.sv
hw/rtl/alternating_bit_byte_bridge_top.sv
hw/rtl/abbb_chk.sv
dv/alternating_bit_byte_bridge_top_tb.sv
